@@ src/tzr_pkg.sv @@
// shared types and constants of the torus z-buffer point renderer
package tzr_pkg;

    localparam int PA_W   = 5;
    localparam int PD_W   = 32;
    localparam int TRIG_W = 16;
    localparam int ACC_W  = 40;
    localparam int MA_W   = 37;
    localparam int MB_W   = 23;
    localparam int P_W    = MA_W + MB_W;
    localparam int DEN_W  = 37;
    localparam int QUOT_W = 16;
    localparam int DEPTH_W = 16;
    localparam int GLYPH_W = 4;
    localparam int ADDR_W  = 11;

    localparam logic signed [ACC_W-1:0] DEN_SAT = 40'sd1073741824;

    localparam logic [2:0] REG_CENTER_COL = 3'd0;
    localparam logic [2:0] REG_CENTER_ROW = 3'd1;
    localparam logic [2:0] REG_SCALE_COL  = 3'd2;
    localparam logic [2:0] REG_SCALE_ROW  = 3'd3;
    localparam logic [2:0] REG_VIEWER     = 3'd4;
    localparam logic [2:0] REG_MAJOR      = 3'd5;

    typedef logic signed [TRIG_W-1:0] t_trig;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [GLYPH_W-1:0] glyph;
    } t_cell;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_stat;

endpackage

@@ src/tzr_sine_rom.sv @@
// quarter-wave sine table with quadrant folding, 1.15 output
module tzr_sine_rom #(
    parameter int ANGLE_BITS = 10
) (
    input  logic [ANGLE_BITS-1:0] i_angle,
    output tzr_pkg::t_trig        o_value
);
    import tzr_pkg::*;

    localparam int QBITS = ANGLE_BITS - 2;
    localparam int QN    = 1 << QBITS;
    localparam int IW    = QBITS + 1;

    function automatic logic [14:0] quarter_sine(input int r, input int qbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned v;
        int k;
        x  = (64'(r) * 64'd1686629713) >> qbits;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (k = 10; k >= 2; k -= 2) begin
            t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'(k * (k + 1)));
        end
        v = (x * t) >> 30;
        v = (v + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return 15'(v);
    endfunction

    logic [14:0] w_tab [QN+1];

    for (genvar gi = 0; gi <= QN; gi++) begin : g_tab
        localparam logic [14:0] TV = quarter_sine(gi, QBITS);
        assign w_tab[gi] = TV;
    end

    logic [1:0]       w_quad;
    logic [QBITS-1:0] w_r;
    logic [IW-1:0]    w_idx;
    t_trig            w_mag;

    assign w_quad = i_angle[ANGLE_BITS-1 -: 2];
    assign w_r    = i_angle[QBITS-1:0];
    assign w_idx  = w_quad[0] ? (IW'(QN) - {1'b0, w_r}) : {1'b0, w_r};
    assign w_mag  = $signed({1'b0, w_tab[w_idx]});
    assign o_value = w_quad[1] ? -w_mag : w_mag;

endmodule

@@ src/tzr_divider.sv @@
// restoring divider for inverse depth, one quotient bit per cycle
module tzr_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [tzr_pkg::DEN_W-1:0] i_den,
    output tzr_pkg::t_div_stat       o_stat
);
    import tzr_pkg::*;

    localparam int REM_W = 47;
    localparam int DSH_W = DEN_W + QUOT_W - 1;

    logic [REM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [3:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [QUOT_W-1:0] r_q;
    logic              w_fit;

    assign w_fit = {{(DSH_W-REM_W){1'b0}}, r_rem} >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= REM_W'(1) << 46;
                r_dsh  <= {i_den, {(QUOT_W-1){1'b0}}};
                r_cnt  <= 4'd15;
                r_q    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_fit) begin
                    r_rem <= r_rem - REM_W'(r_dsh);
                end
                r_q   <= {r_q[QUOT_W-2:0], w_fit};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_q;

endmodule

@@ src/tzr_cell_mem.sv @@
// screen cell memory holding depth and glyph, one write and one registered read
module tzr_cell_mem #(
    parameter int DEPTH = 1760,
    parameter int AW    = 11
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tzr_pkg::t_cell  i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output tzr_pkg::t_cell  o_rdata
);
    import tzr_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/torus_zbuffer_point_renderer_core.sv @@
// top level of the torus z-buffer point renderer
// A plot item (action 0) turns four angles into a torus surface point, rotates
// and projects it onto a COLS x ROWS character screen and keeps it in the cell
// only when it is strictly inside the screen and nearer than the stored depth;
// the result tells the cell and glyph written (drawn 1), or the hidden cell
// with glyph 0, or all zero for a dropped or off-screen point. A read item
// (action 1) returns a cell's glyph and clears it. One item is in flight at a
// time. A plot goes from the accepting state through 8 sine lookups through one
// table, 20 steps of one shared 37x23 multiplier with a wait on the bit-serial
// inverse depth divider after the sixteenth, one cell memory read, one compare
// and write, and the load of the output register. A saturating depth skips the
// divider, a non-positive depth denominator ends after the first 16 multiplier
// steps, and an off-screen point skips the compare. A read goes from acceptance
// through the read-and-clear state to the output load, skipping that state when
// beyond the screen. After reset the block sweeps the cell memory, depth and
// glyph, to zero, one cell a cycle over all COLS*ROWS cells (1760 by default)
// before taking items; configuration writes are taken meanwhile. The finished
// result waits in an output register, so the next item is taken while it sits
// unclaimed; a result unclaimed there holds the following one in its last state.
module torus_zbuffer_point_renderer_core #(
    parameter int COLS       = 80,
    parameter int ROWS       = 22,
    parameter int ANGLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tzr_pkg::PA_W-1:0]      paddr,
    input  logic [tzr_pkg::PD_W-1:0]      pwdata,
    output logic [tzr_pkg::PD_W-1:0]      prdata,
    output logic                          pready,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [9:0]                    i_sweep_angle,
    input  logic [9:0]                    i_tube_angle,
    input  logic [9:0]                    i_rot_a,
    input  logic [9:0]                    i_rot_b,
    input  logic [tzr_pkg::ADDR_W-1:0]    i_cell_addr,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tzr_pkg::GLYPH_W-1:0]   o_glyph,
    output logic                          o_drawn,
    output logic [tzr_pkg::ADDR_W-1:0]    o_cell_out
);
    import tzr_pkg::*;

    localparam int CELLS = COLS * ROWS;
    localparam int CW    = $clog2(CELLS);
    localparam int AB    = ANGLE_BITS;
    localparam int QN    = 1 << (ANGLE_BITS - 2);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_LOOK  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_CELL  = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_RD    = 9'b010000000,
        S_FIN   = 9'b100000000
    } t_state;

    // microsteps of the shared multiplier
    typedef enum logic [4:0] {
        ST_CH   = 5'd0,  ST_LH   = 5'd1,  ST_CH_E = 5'd2,  ST_FG   = 5'd3,
        ST_CH_G = 5'd4,  ST_FE   = 5'd5,  ST_LH_M = 5'd6,  ST_TQ_N = 5'd7,
        ST_LH_N = 5'd8,  ST_TQ_M = 5'd9,  ST_CD   = 5'd10, ST_CD_G = 5'd11,
        ST_U_M  = 5'd12, ST_CD_E = 5'd13, ST_LD   = 5'd14, ST_LD_N = 5'd15,
        ST_SC_C = 5'd16, ST_CX   = 5'd17, ST_SC_R = 5'd18, ST_CY   = 5'd19
    } t_step;

    // configuration registers
    logic [6:0] r_center_col;
    logic [4:0] r_center_row;
    logic [5:0] r_scale_col;
    logic [4:0] r_scale_row;
    logic [4:0] r_viewer;
    logic [2:0] r_major;

    t_state r_state;
    t_step  r_step;
    logic [2:0]  r_look;
    logic [CW-1:0] r_clr;

    // latched item
    logic [AB-1:0] r_sweep, r_tube, r_ra, r_rb;
    logic [CW-1:0] r_rd_addr;

    // trig values: c,l sweep; f,d tube; e,g rot a; n,m rot b
    t_trig r_c, r_l, r_f, r_d, r_e, r_g, r_n, r_m;

    // intermediate products
    logic signed [ACC_W-1:0] r_ch, r_lh, r_den, r_fg, r_tq, r_fe, r_px, r_py;
    logic signed [ACC_W-1:0] r_cd, r_u, r_lum, r_ld, r_sc;
    logic signed [15:0]      r_cx, r_cy;
    logic [QUOT_W-1:0]       r_dinv;
    logic [CW-1:0]           r_cell;

    // pending result and output register
    logic [GLYPH_W-1:0] r_res_glyph;
    logic               r_res_drawn;
    logic [ADDR_W-1:0]  r_res_cell;
    logic               r_out_valid;
    logic [GLYPH_W-1:0] r_out_glyph;
    logic               r_out_drawn;
    logic [ADDR_W-1:0]  r_out_cell;

    logic                    w_cfg_we;
    logic [AB-1:0]           w_angle;
    t_trig                   w_sin;
    logic signed [MA_W-1:0]  w_h;
    logic signed [MA_W-1:0]  w_ma;
    logic signed [MB_W-1:0]  w_mb;
    logic signed [P_W-1:0]   w_p;
    logic signed [ACC_W-1:0] w_p15;
    logic signed [15:0]      w_p46;
    logic signed [ACC_W-1:0] w_lum_sh;
    logic [GLYPH_W-1:0]      w_idx;
    logic [CW-1:0]           w_cell;
    logic                    w_inside;
    logic                    w_div_start;
    t_div_stat               w_div;
    logic                    w_we;
    logic [CW-1:0]           w_waddr;
    t_cell                   w_wdata;
    logic [CW-1:0]           w_raddr;
    t_cell                   w_rdata;
    logic                    w_hit;

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[4:2])
            REG_CENTER_COL: prdata = PD_W'(r_center_col);
            REG_CENTER_ROW: prdata = PD_W'(r_center_row);
            REG_SCALE_COL:  prdata = PD_W'(r_scale_col);
            REG_SCALE_ROW:  prdata = PD_W'(r_scale_row);
            REG_VIEWER:     prdata = PD_W'(r_viewer);
            REG_MAJOR:      prdata = PD_W'(r_major);
            default:        prdata = '0;
        endcase
    end

    // ---------------- sine lookup ----------------
    // even lookups give sine, odd ones cosine by a quarter-turn offset
    always_comb begin
        unique case (r_look[2:1])
            2'd0: w_angle = r_sweep;
            2'd1: w_angle = r_tube;
            2'd2: w_angle = r_ra;
            2'd3: w_angle = r_rb;
            default: w_angle = r_sweep;
        endcase
        if (r_look[0]) begin
            w_angle = w_angle + AB'(QN);
        end
    end

    tzr_sine_rom #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sine (
        .i_angle (w_angle),
        .o_value (w_sin)
    );

    // ---------------- shared multiplier ----------------
    // tube center distance h = cos(tube) + major radius
    assign w_h = MA_W'(r_d) + $signed(MA_W'({r_major, 15'd0}));

    always_comb begin
        unique case (r_step)
            ST_CH:   begin w_ma = w_h;              w_mb = MB_W'(r_c); end
            ST_LH:   begin w_ma = w_h;              w_mb = MB_W'(r_l); end
            ST_CH_E: begin w_ma = MA_W'(r_ch);      w_mb = MB_W'(r_e); end
            ST_FG:   begin w_ma = MA_W'(r_f);       w_mb = MB_W'(r_g); end
            ST_CH_G: begin w_ma = MA_W'(r_ch);      w_mb = MB_W'(r_g); end
            ST_FE:   begin w_ma = MA_W'(r_f);       w_mb = MB_W'(r_e); end
            ST_LH_M: begin w_ma = MA_W'(r_lh);      w_mb = MB_W'(r_m); end
            ST_TQ_N: begin w_ma = MA_W'(r_tq);      w_mb = MB_W'(r_n); end
            ST_LH_N: begin w_ma = MA_W'(r_lh);      w_mb = MB_W'(r_n); end
            ST_TQ_M: begin w_ma = MA_W'(r_tq);      w_mb = MB_W'(r_m); end
            ST_CD:   begin w_ma = MA_W'(r_c);       w_mb = MB_W'(r_d); end
            ST_CD_G: begin w_ma = MA_W'(r_cd);      w_mb = MB_W'(r_g); end
            ST_U_M:  begin w_ma = MA_W'(r_u);       w_mb = MB_W'(r_m); end
            ST_CD_E: begin w_ma = MA_W'(r_cd);      w_mb = MB_W'(r_e); end
            ST_LD:   begin w_ma = MA_W'(r_l);       w_mb = MB_W'(r_d); end
            ST_LD_N: begin w_ma = MA_W'(r_ld);      w_mb = MB_W'(r_n); end
            ST_SC_C: begin
                w_ma = $signed(MA_W'(r_dinv));
                w_mb = $signed(MB_W'(r_scale_col));
            end
            ST_CX:   begin w_ma = MA_W'(r_px);      w_mb = MB_W'(r_sc); end
            ST_SC_R: begin
                w_ma = $signed(MA_W'(r_dinv));
                w_mb = $signed(MB_W'(r_scale_row));
            end
            ST_CY:   begin w_ma = MA_W'(r_py);      w_mb = MB_W'(r_sc); end
            default: begin w_ma = '0;               w_mb = '0; end
        endcase
    end

    assign w_p   = w_ma * w_mb;
    assign w_p15 = ACC_W'(w_p >>> 15);
    assign w_p46 = 16'(w_p >>> 46);

    // ---------------- divider ----------------
    // non-saturating positive depth denominators go through the divider
    assign w_div_start = (r_state == S_MUL) && (r_step == ST_LD_N) && (r_den > DEN_SAT);

    tzr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (r_den[DEN_W-1:0]),
        .o_stat  (w_div)
    );

    // ---------------- luminance and cell ----------------
    assign w_lum_sh = r_lum >>> 27;

    always_comb begin
        if (r_lum <= 0) begin
            w_idx = '0;
        end else if (w_lum_sh > 11) begin
            w_idx = 4'd11;
        end else begin
            w_idx = 4'(w_lum_sh);
        end
    end

    assign w_inside = (r_cx > 0) && (r_cx < $signed(16'(COLS)))
                   && (r_cy > 0) && (r_cy < $signed(16'(ROWS)));
    assign w_cell   = CW'(r_cx) + CW'(COLS) * CW'(r_cy);

    // ---------------- cell memory ----------------
    assign w_raddr = (r_state == S_IDLE) ? CW'(i_cell_addr) : w_cell;
    assign w_hit   = r_dinv > w_rdata.depth;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        unique case (r_state)
            S_CLEAR: w_we = 1'b1;
            S_CMP: begin
                w_we          = w_hit;
                w_waddr       = r_cell;
                w_wdata.depth = r_dinv;
                w_wdata.glyph = w_idx + 4'd1;
            end
            S_RD: begin
                // read and clear
                w_we    = 1'b1;
                w_waddr = r_rd_addr;
            end
            default: w_we = 1'b0;
        endcase
    end

    tzr_cell_mem #(
        .DEPTH (CELLS),
        .AW    (CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // ---------------- sequencer ----------------
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_step       <= ST_CH;
            r_look       <= '0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_center_col <= 7'd40;
            r_center_row <= 5'd12;
            r_scale_col  <= 6'd30;
            r_scale_row  <= 5'd15;
            r_viewer     <= 5'd5;
            r_major      <= 3'd2;
        end else begin
            if (w_cfg_we) begin
                unique case (paddr[4:2])
                    REG_CENTER_COL: r_center_col <= pwdata[6:0];
                    REG_CENTER_ROW: r_center_row <= pwdata[4:0];
                    REG_SCALE_COL:  r_scale_col  <= pwdata[5:0];
                    REG_SCALE_ROW:  r_scale_row  <= pwdata[4:0];
                    REG_VIEWER:     r_viewer     <= pwdata[4:0];
                    REG_MAJOR:      r_major      <= pwdata[2:0];
                    default:        r_major      <= r_major;
                endcase
            end

            // the finishing state reloads the output register itself
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_res_glyph <= '0;
                        r_res_drawn <= 1'b0;
                        if (i_action) begin
                            r_res_cell <= i_cell_addr;
                            r_rd_addr  <= CW'(i_cell_addr);
                            // a read beyond the screen clears nothing
                            r_state    <= (32'(i_cell_addr) < CELLS) ? S_RD : S_FIN;
                        end else begin
                            r_res_cell <= '0;
                            r_sweep    <= AB'(i_sweep_angle);
                            r_tube     <= AB'(i_tube_angle);
                            r_ra       <= AB'(i_rot_a);
                            r_rb       <= AB'(i_rot_b);
                            r_look     <= '0;
                            r_state    <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    unique case (r_look)
                        3'd0: r_c <= w_sin;
                        3'd1: r_l <= w_sin;
                        3'd2: r_f <= w_sin;
                        3'd3: r_d <= w_sin;
                        3'd4: r_e <= w_sin;
                        3'd5: r_g <= w_sin;
                        3'd6: r_n <= w_sin;
                        3'd7: r_m <= w_sin;
                        default: r_m <= w_sin;
                    endcase
                    r_look <= r_look + 3'd1;
                    if (r_look == 3'd7) begin
                        r_step  <= ST_CH;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_step <= t_step'(r_step + 5'd1);
                    unique case (r_step)
                        ST_CH:   r_ch <= ACC_W'(w_p);
                        ST_LH:   r_lh <= ACC_W'(w_p);
                        ST_CH_E: r_den <= w_p15;
                        ST_FG: begin
                            r_fg  <= ACC_W'(w_p);
                            r_den <= r_den + ACC_W'(w_p)
                                   + $signed(ACC_W'({r_viewer, 30'd0}));
                        end
                        ST_CH_G: r_tq <= w_p15;
                        ST_FE: begin
                            r_fe <= ACC_W'(w_p);
                            r_tq <= r_tq - ACC_W'(w_p);
                        end
                        ST_LH_M: r_px <= w_p15;
                        ST_TQ_N: r_px <= r_px - w_p15;
                        ST_LH_N: r_py <= w_p15;
                        ST_TQ_M: r_py <= r_py + w_p15;
                        ST_CD:   r_cd <= ACC_W'(w_p);
                        ST_CD_G: r_u  <= r_fe - w_p15;
                        ST_U_M:  r_lum <= w_p15 - r_fg;
                        ST_CD_E: r_lum <= r_lum - w_p15;
                        ST_LD:   r_ld <= ACC_W'(w_p);
                        ST_LD_N: begin
                            r_lum <= r_lum - w_p15;
                            // depth denominator settled since the f*g step
                            if (r_den <= 0) begin
                                r_state <= S_FIN;
                            end else if (r_den <= DEN_SAT) begin
                                r_dinv <= '1;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        ST_SC_C: r_sc <= ACC_W'(w_p);
                        ST_CX:   r_cx <= $signed(16'(r_center_col)) + w_p46;
                        ST_SC_R: r_sc <= ACC_W'(w_p);
                        ST_CY: begin
                            r_cy    <= $signed(16'(r_center_row)) + w_p46;
                            r_state <= S_CELL;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_dinv  <= w_div.quot;
                        r_step  <= ST_SC_C;
                        r_state <= S_MUL;
                    end
                end
                S_CELL: begin
                    r_cell  <= w_cell;
                    r_state <= w_inside ? S_CMP : S_FIN;
                end
                S_CMP: begin
                    r_res_cell <= ADDR_W'(r_cell);
                    if (w_hit) begin
                        r_res_glyph <= w_idx + 4'd1;
                        r_res_drawn <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_RD: begin
                    r_res_glyph <= w_rdata.glyph;
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_glyph <= r_res_glyph;
                        r_out_drawn <= r_res_drawn;
                        r_out_cell  <= r_res_cell;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_glyph     = r_out_glyph;
    assign o_drawn     = r_out_drawn;
    assign o_cell_out  = r_out_cell;

    // ---------------- assertions ----------------
    a_drawn_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drawn) |-> (o_glyph != 4'd0))
        else $error("drawn result carries a blank glyph");

    a_glyph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_glyph <= 4'd12))
        else $error("glyph beyond the luminance ramp");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_den > DEN_SAT))
        else $error("divider running on a saturating denominator");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !o_in_ready)
        else $error("cell memory written while taking an item");

endmodule
